FILE: hw/rtl/bitmap_best_fit_block_allocator_top_defines.svh
// Assertion macros shared by the allocator's controller and datapath.
`ifndef BITMAP_BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_BEST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define BBFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bbfa: same-cycle check failed");

// Next-cycle implication, checked on i_clk, off during reset.
`define BBFA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bbfa: next-cycle check failed");

`endif

FILE: hw/rtl/bbfa_pkg.sv
// Shared field widths, request and status codes, and controller/datapath structs.
`timescale 1ns / 1ps

package bbfa_pkg;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned BLOCK_W  = 12;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned MAPB_W   = 10;
    localparam int unsigned FREE_W   = 13;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic [MAPB_W-1:0] MAP_BYTES_RESET = 10'd512;

    // Request kinds
    localparam logic [KIND_W-1:0] K_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] K_DEALLOC = 3'd1;
    localparam logic [KIND_W-1:0] K_READ    = 3'd2;
    localparam logic [KIND_W-1:0] K_WRITE   = 3'd3;
    localparam logic [KIND_W-1:0] K_STATS   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

    typedef struct packed {
        logic clr;        // write one cleared map bit, advance the sweep
        logic load;       // capture the accepted request
        logic scan_init;  // set the scan range, reset run trackers
        logic scan;       // issue map reads and fold in returned bits
        logic fill_init;  // set the write range and value
        logic fill;       // write one map bit per cycle
        logic out_load;   // capture the result into the output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;   // sweep is at the last map bit
        logic arg_ok;     // request arguments are in range
        logic skip_scan;  // request needs no read pass
        logic scan_done;  // all reads issued and folded in
        logic need_fill;  // scan outcome calls for a write pass
        logic fill_done;  // write pass finished
    } t_sts;

endpackage

FILE: hw/rtl/bbfa_dp.sv
// Datapath: allocation map memory, scan and fill counters, run trackers, result register.
`timescale 1ns / 1ps

`include "bitmap_best_fit_block_allocator_top_defines.svh"

module bbfa_dp
    import bbfa_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [MAPB_W-1:0]   i_cfg_data,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [BLOCK_W-1:0]  i_block,
    input  logic [COUNT_W-1:0]  i_count,
    input  logic                i_value,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic [STATUS_W-1:0] o_status,
    output logic [BLOCK_W-1:0]  o_grant_base,
    output logic                o_bit_value,
    output logic [FREE_W-1:0]   o_free_total,
    output logic [FREE_W-1:0]   o_largest_free
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = $clog2(MAX_BLOCKS + 2);
    localparam int XW = ((SW > COUNT_W) ? SW : COUNT_W) + 1;

    logic [MAPB_W-1:0]  r_map_bytes;
    logic [KIND_W-1:0]  r_kind;
    logic [BLOCK_W-1:0] r_block;
    logic [COUNT_W-1:0] r_count;
    logic               r_value;

    logic [XW-1:0] x_mb8, x_max, x_total, x_block, x_count, x_best;
    logic [XW-1:0] x_free, x_largest;
    logic [CW-1:0] w_total;
    logic          arg_ok;

    logic          r_mem [0:MAX_BLOCKS-1];
    logic [SW-1:0] r_addr, r_end, scan_lo, scan_hi;
    logic          r_rd_vld, r_rd_term, r_rd_data;
    logic [SW-1:0] r_rd_idx;
    logic          issue, term_issue, rd_en, bit_now;

    logic [CW-1:0] r_run, r_best_len, r_free, r_largest, run_inc;
    logic [AW-1:0] r_run_start, r_best_start;
    logic          r_found, r_any_free, r_bitv;

    logic [AW-1:0] r_waddr, waddr;
    logic [CW-1:0] r_wleft, fill_len;
    logic          r_wval, fill_val, we, wdata;

    logic [STATUS_W-1:0] n_status, r_status;
    logic [BLOCK_W-1:0]  n_start, r_start;
    logic                n_bitv, r_bitv_out;
    logic [FREE_W-1:0]   n_free, r_free_out, n_largest, r_largest_out;

    // Blocks in use, capped at the map depth
    assign x_mb8   = XW'({r_map_bytes, 3'b000});
    assign x_max   = XW'(MAX_BLOCKS);
    assign w_total = CW'((x_mb8 > x_max) ? x_max : x_mb8);
    assign x_total = XW'(w_total);
    assign x_block = XW'(r_block);
    assign x_count = XW'(r_count);

    always_comb begin
        case (r_kind)
            K_ALLOC:   arg_ok = (x_count != '0) && (x_count <= x_total);
            K_DEALLOC: arg_ok = (x_count != '0) && (x_block < x_total)
                                && (x_count <= (x_total - x_block));
            K_READ:    arg_ok = (x_block < x_total);
            K_WRITE:   arg_ok = (x_block < x_total);
            K_STATS:   arg_ok = 1'b1;
            default:   arg_ok = 1'b0;
        endcase
    end

    // Allocate scans one index past the end; that index closes the last run
    always_comb begin
        case (r_kind)
            K_ALLOC: begin
                scan_lo = '0;
                scan_hi = SW'(x_total + XW'(1));
            end
            K_DEALLOC: begin
                scan_lo = SW'(x_block);
                scan_hi = SW'(x_block + x_count);
            end
            K_READ: begin
                scan_lo = SW'(x_block);
                scan_hi = SW'(x_block + XW'(1));
            end
            default: begin
                scan_lo = '0;
                scan_hi = SW'(x_total);
            end
        endcase
    end

    assign issue      = i_cmd.scan && (r_addr < r_end);
    assign term_issue = (r_kind == K_ALLOC) && (r_addr == SW'(x_total));
    assign rd_en      = issue && !term_issue;
    assign bit_now    = r_rd_term | r_rd_data;
    assign run_inc    = r_run + CW'(1);

    assign fill_len = (r_kind == K_WRITE) ? CW'(1) : x_count[CW-1:0];
    always_comb begin
        case (r_kind)
            K_ALLOC:   fill_val = 1'b1;
            K_DEALLOC: fill_val = 1'b0;
            default:   fill_val = r_value;
        endcase
    end

    assign we    = i_cmd.clr || (i_cmd.fill && (r_wleft != '0));
    assign waddr = i_cmd.clr ? r_addr[AW-1:0] : r_waddr;
    assign wdata = i_cmd.clr ? 1'b0 : r_wval;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_bytes <= MAP_BYTES_RESET;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_wleft     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_map_bytes <= i_cfg_data;
            end
            r_rd_vld <= issue;
            if (i_cmd.clr || issue) begin
                r_addr <= r_addr + SW'(1);
            end else if (i_cmd.scan_init) begin
                r_addr <= scan_lo;
            end
            if (i_cmd.fill_init) begin
                r_wleft <= fill_len;
            end else if (i_cmd.fill && (r_wleft != '0)) begin
                r_wleft <= r_wleft - CW'(1);
            end
        end
    end

    // Map memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
    end

    // Request, ranges and read tags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_block <= i_block;
            r_count <= i_count;
            r_value <= i_value;
        end
        if (i_cmd.scan_init) begin
            r_end <= scan_hi;
        end
        if (issue) begin
            r_rd_idx  <= r_addr;
            r_rd_term <= term_issue;
        end
        if (i_cmd.fill_init) begin
            r_waddr <= (r_kind == K_ALLOC) ? r_best_start : x_block[AW-1:0];
            r_wval  <= fill_val;
        end else if (we && !i_cmd.clr) begin
            r_waddr <= r_waddr + AW'(1);
        end
    end

    // Fold each returned bit into the run trackers
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_run        <= '0;
            r_run_start  <= '0;
            r_best_len   <= '0;
            r_best_start <= '0;
            r_found      <= 1'b0;
            r_any_free   <= 1'b0;
            r_bitv       <= 1'b0;
            r_free       <= '0;
            r_largest    <= '0;
        end else if (r_rd_vld) begin
            case (r_kind)
                K_ALLOC: begin
                    if (!bit_now) begin
                        if (r_run == '0) begin
                            r_run_start <= r_rd_idx[AW-1:0];
                        end
                        r_run <= run_inc;
                    end else begin
                        // strict compare keeps the earliest run on a tie
                        if ((XW'(r_run) >= x_count) && (!r_found || (r_run < r_best_len))) begin
                            r_found      <= 1'b1;
                            r_best_len   <= r_run;
                            r_best_start <= r_run_start;
                        end
                        r_run <= '0;
                    end
                end
                K_DEALLOC: begin
                    if (!bit_now) begin
                        r_any_free <= 1'b1;
                    end
                end
                K_READ: begin
                    r_bitv <= bit_now;
                end
                K_STATS: begin
                    if (!bit_now) begin
                        r_free <= r_free + CW'(1);
                        r_run  <= run_inc;
                        if (run_inc > r_largest) begin
                            r_largest <= run_inc;
                        end
                    end else begin
                        r_run <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign x_best    = XW'(r_best_start);
    assign x_free    = XW'(r_free);
    assign x_largest = XW'(r_largest);

    // Result fields; anything that does not apply reads as zero
    always_comb begin
        n_status  = ST_OK;
        n_start   = '0;
        n_bitv    = 1'b0;
        n_free    = '0;
        n_largest = '0;
        if (!arg_ok) begin
            n_status = ST_INVALID;
        end else begin
            case (r_kind)
                K_ALLOC: begin
                    n_status = r_found ? ST_OK : ST_NOFIT;
                    n_start  = r_found ? x_best[BLOCK_W-1:0] : '0;
                end
                K_DEALLOC: n_status = r_any_free ? ST_ALREADY_FREE : ST_OK;
                K_READ:    n_bitv = r_bitv;
                K_STATS: begin
                    n_free    = x_free[FREE_W-1:0];
                    n_largest = x_largest[FREE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status      <= n_status;
            r_start       <= n_start;
            r_bitv_out    <= n_bitv;
            r_free_out    <= n_free;
            r_largest_out <= n_largest;
        end
    end

    assign o_status       = r_status;
    assign o_grant_base   = r_start;
    assign o_bit_value    = r_bitv_out;
    assign o_free_total   = r_free_out;
    assign o_largest_free = r_largest_out;

    assign o_sts.clr_last  = (r_addr == SW'(MAX_BLOCKS - 1));
    assign o_sts.arg_ok    = arg_ok;
    assign o_sts.skip_scan = (r_kind == K_WRITE);
    assign o_sts.scan_done = (r_addr == r_end) && !r_rd_vld;
    assign o_sts.need_fill = ((r_kind == K_ALLOC) && r_found)
                             || ((r_kind == K_DEALLOC) && !r_any_free)
                             || (r_kind == K_WRITE);
    assign o_sts.fill_done = (r_wleft == '0);

    `BBFA_ASSERT_IMP(a_fill_no_read, r_wleft != '0, !r_rd_vld)
    `BBFA_ASSERT_IMP(a_scan_in_bounds, i_cmd.scan, r_addr <= r_end)

endmodule

FILE: hw/rtl/bbfa_ctrl.sv
// Controller: sequences clear sweep, argument check, scan pass, fill pass and result hand-off.
`timescale 1ns / 1ps

`include "bitmap_best_fit_block_allocator_top_defines.svh"

module bbfa_ctrl
    import bbfa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_FILL,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld;
    logic   slot_free;

    assign slot_free = !r_out_vld || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.arg_ok) begin
                    n_state = S_DONE;
                end else if (i_sts.skip_scan) begin
                    o_cmd.fill_init = 1'b1;
                    n_state         = S_FILL;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    if (i_sts.need_fill) begin
                        o_cmd.fill_init = 1'b1;
                        n_state         = S_FILL;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    `BBFA_ASSERT_NXT(a_scan_to_fill, (r_state == S_SCAN) && i_sts.scan_done && i_sts.need_fill, r_state == S_FILL)
    `BBFA_ASSERT_NXT(a_done_waits, (r_state == S_DONE) && r_out_vld && !i_out_ready, (r_state == S_DONE) && r_out_vld)

endmodule

FILE: hw/rtl/bitmap_best_fit_block_allocator_top.sv
// Top level of the best-fit bitmap block allocator: stream ports, controller and datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tuser kind, tdata request fields
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata result fields
// cfg       in         i_cfg_valid/o_cfg_ready          map_bytes
//
// One item at a time. A scan pass reads one map bit per cycle through the
// map memory's read port, then a fill pass writes one bit per cycle through
// its write port. After reset a clearing pass zeroes the map; no item is
// taken until it ends, config writes are.
// The next item is taken while a finished result waits in the output
// register; a stalled output holds the following result in the controller.

module bitmap_best_fit_block_allocator_top
    import bbfa_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request item
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [11:0] block, [24:12] count, [25] value, [31:26] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] kind
    input  logic [KIND_W-1:0]     i_s_axis_tuser,
    // result item
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [1:0] status, [13:2] grant_base, [14] bit_value,
    // [27:15] free_total, [40:28] largest_free, [47:41] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // map_bytes write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [MAPB_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  grant_base;
    logic                bit_value;
    logic [FREE_W-1:0]   free_total;
    logic [FREE_W-1:0]   largest_free;

    // Map size writes land at once; the host must write only while idle, which the block does not enforce
    assign o_cfg_ready = 1'b1;

    bbfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bbfa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_s_axis_tuser),
        .i_block        (i_s_axis_tdata[11:0]),
        .i_count        (i_s_axis_tdata[24:12]),
        .i_value        (i_s_axis_tdata[25]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_status       (status),
        .o_grant_base   (grant_base),
        .o_bit_value    (bit_value),
        .o_free_total   (free_total),
        .o_largest_free (largest_free)
    );

    // Pack the result fields, lowest field first, pad to whole bytes
    assign o_m_axis_tdata = {7'b0, largest_free, free_total, bit_value, grant_base, status};

endmodule
